>>> rtl/lux_change_median_filter_core_defines.svh
// Assertion macros shared by the lux change median filter checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef LUX_CHANGE_MEDIAN_FILTER_CORE_DEFINES_SVH
`define LUX_CHANGE_MEDIAN_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and idle while reset is low.
`define LCMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and idle while reset is low.
`define LCMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lcmf_pkg.sv
// Shared types and constants of the lux change median filter.
// Used by the change detector, the history, the top level and the test bench; depends on nothing.
`timescale 1ns / 1ps

package lcmf_pkg;

    localparam int RAW_W      = 16;
    localparam int LUX_W      = 20;
    localparam int CNT_W      = 2;
    localparam int LUX_SHIFT  = 3;
    localparam int HIST_DEPTH = 3;
    localparam int OUT_DATA_W = 24;

    typedef logic signed [LUX_W-1:0] t_lux;

    // No-data sentinel written into the history on a clear.
    localparam t_lux NO_DATA = -20'sd61;

    // Report limit after reset.
    localparam logic [CNT_W-1:0] REPORT_AFTER_RST = 2'd2;

    // Item kind carried on tuser.
    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_CLEAR  = 1'b1
    } t_kind;

    // Control from the top level to the history.
    typedef struct packed {
        logic shift;
        logic fill;
    } t_hist_ctrl;

    // Median pick table, indexed by the three compare results.
    localparam logic [1:0] MEDIAN_PICK [8] = '{2'd1, 2'd0, 2'd2, 2'd0,
                                               2'd0, 2'd2, 2'd0, 2'd1};

endpackage

>>> rtl/lcmf_change_det.sv
// Lux scaling and change threshold test against the reported value.
// Depends on lcmf_pkg.
`timescale 1ns / 1ps

module lcmf_change_det (
    input  logic [lcmf_pkg::RAW_W-1:0] i_raw,
    input  lcmf_pkg::t_lux             i_reported,
    output lcmf_pkg::t_lux             o_lux,
    output logic                       o_over
);
    import lcmf_pkg::*;

    logic signed [LUX_W:0] w_diff;
    logic [LUX_W-1:0]      w_abs;
    logic [LUX_W+2:0]      w_five;
    logic [LUX_W+2:0]      w_rep_ext;

    // Scale by eight: the lux value is always non-negative.
    assign o_lux = t_lux'({1'b0, i_raw, {LUX_SHIFT{1'b0}}});

    // Absolute difference against the reported value.
    assign w_diff = {o_lux[LUX_W-1], o_lux} - {i_reported[LUX_W-1], i_reported};
    assign w_abs  = w_diff[LUX_W] ? LUX_W'(-w_diff) : w_diff[LUX_W-1:0];

    // For a non-negative reported value r, diff > r/5 holds exactly when 5*diff > r.
    assign w_five    = {w_abs, 2'b00} + {3'b000, w_abs};
    assign w_rep_ext = {3'b000, i_reported};

    // A negative reported value has a negative threshold, so every sample is over.
    assign o_over = i_reported[LUX_W-1] || (w_five > w_rep_ext);

endmodule

>>> rtl/lcmf_history.sv
// Three-deep lux history with median-of-three selection.
// Depends on lcmf_pkg.
`timescale 1ns / 1ps

module lcmf_history (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcmf_pkg::t_hist_ctrl i_ctrl,
    input  lcmf_pkg::t_lux      i_lux,
    output lcmf_pkg::t_lux      o_median
);
    import lcmf_pkg::*;

    t_lux       r_hist [HIST_DEPTH];
    t_lux       w_cand [HIST_DEPTH];
    logic [2:0] w_sel;

    // History update: a clear refills with the sentinel, a shift pushes the new lux.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= NO_DATA;
            end
        end else if (i_ctrl.fill) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= NO_DATA;
            end
        end else if (i_ctrl.shift) begin
            r_hist[0] <= i_lux;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // The median is taken over the history as it stands after the shift.
    assign w_cand[0] = i_lux;
    assign w_cand[1] = r_hist[0];
    assign w_cand[2] = r_hist[1];

    assign w_sel = {w_cand[0] > w_cand[1], w_cand[1] > w_cand[2], w_cand[0] > w_cand[2]};
    assign o_median = w_cand[MEDIAN_PICK[w_sel]];

endmodule

>>> rtl/lux_change_median_filter_core.sv
// Channel   | Dir | Handshake           | Payload
// s (in)    | in  | i_s_tvalid/o_s_tready | tdata = raw_reading, tuser = kind
// m (out)   | out | o_m_tvalid/i_m_tready | tdata = lux_value (zero padded)
// cfg       | in  | i_cfg_we            | i_cfg_wdata = report_after
//
// One request per cycle sustained while no reporting request waits on a held
// result; requests pass the input register and results the output register.
// The input register feeds one pass of compare, count and median logic into the
// output register. Reset is synchronous active low and returns the history to
// the sentinel, the reported value to zero and the report limit to two.
// A held result stalls an input request only when that request also reports.
`timescale 1ns / 1ps

module lux_change_median_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] raw_reading
    input  logic [0:0]  i_s_tuser,   // [0] kind
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [19:0] lux_value, [23:20] zero
    // Configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata
);
    import lcmf_pkg::*;

    logic             r_in_valid;
    t_kind            r_in_kind;
    logic [RAW_W-1:0] r_in_raw;
    t_lux             r_rep;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_ra;
    logic             r_out_valid;
    t_lux             r_out_lux;

    logic [CNT_W-1:0] n_cnt;
    t_lux             w_lux;
    t_lux             w_median;
    logic             w_over;
    logic             w_sample;
    logic [CNT_W:0]   w_cnt_inc;
    logic [CNT_W:0]   w_limit;
    logic             w_emit;
    logic             w_out_free;
    logic             w_fire;
    t_hist_ctrl       w_hctl;

    // Threshold test of the registered sample.
    lcmf_change_det u_det (
        .i_raw      (r_in_raw),
        .i_reported (r_rep),
        .o_lux      (w_lux),
        .o_over     (w_over)
    );

    // History and median.
    lcmf_history u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_hctl),
        .i_lux    (w_lux),
        .o_median (w_median)
    );

    // Count and report decision; a limit of zero acts as one.
    assign w_sample  = (r_in_kind == KIND_SAMPLE);
    assign w_cnt_inc = {1'b0, r_cnt} + (CNT_W+1)'(1);
    assign w_limit   = (r_ra == '0) ? (CNT_W+1)'(1) : {1'b0, r_ra};
    assign w_emit    = w_sample && w_over && (w_cnt_inc >= w_limit);

    // The held item moves on unless it reports into a full, stalled output register.
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_fire     = r_in_valid && (!w_emit || w_out_free);
    assign o_s_tready = !r_in_valid || w_fire;

    assign w_hctl.fill  = w_fire && !w_sample;
    assign w_hctl.shift = w_fire && w_sample && w_over;

    always_comb begin
        n_cnt = r_cnt;
        if (w_sample) begin
            if (w_emit || !w_over) begin
                n_cnt = '0;
            end else begin
                n_cnt = w_cnt_inc[CNT_W-1:0];
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_kind <= t_kind'(i_s_tuser[0]);
            r_in_raw  <= i_s_tdata;
        end
    end

    // Filter state and report limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep <= '0;
            r_cnt <= '0;
            r_ra  <= REPORT_AFTER_RST;
        end else begin
            if (i_cfg_we) begin
                r_ra <= i_cfg_wdata;
            end
            if (w_fire) begin
                r_cnt <= n_cnt;
                if (w_emit) begin
                    r_rep <= w_median;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out_lux <= w_median;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-LUX_W){1'b0}}, r_out_lux};

endmodule

>>> rtl/lcmf_checker.sv
// Port-level checker for the lux change median filter, bound to the top level.
// Depends on lux_change_median_filter_core_defines.svh.
`timescale 1ns / 1ps
`include "lux_change_median_filter_core_defines.svh"

module lcmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    // A stalled result holds its data.
    `LCMF_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")

    // Input backpressure only comes from a stalled output.
    `LCMF_ASSERT_NOW(a_ready_cause, !o_s_tready, o_m_tvalid && !i_m_tready, "input stalled without output stall")

    // A reported value is the sentinel or a padded multiple of eight.
    `LCMF_ASSERT_NOW(a_out_range, o_m_tvalid, (o_m_tdata == 24'h0FFFC3) || (o_m_tdata[23:19] == 5'd0 && o_m_tdata[2:0] == 3'd0), "reported value out of range")

endmodule

bind lux_change_median_filter_core lcmf_checker u_lcmf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

>>> verif/lcmf_report_checker.sv
// Checker for the lux change median filter: watches both streams and the config port.
// It predicts every lux report and compares it with the output stream.
// Depends on lcmf_pkg for the request kind.
`timescale 1ns / 1ps

module lcmf_report_checker
    import lcmf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] raw_reading
    input  logic [0:0]  i_s_tuser,   // [0] kind
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [19:0] lux_value, [23:20] zero
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    output int          o_errors,
    output int          o_pending
);

    // Lux values are kept one bit wider than the output field and signed so the sentinel fits.
    typedef logic signed [20:0] t_wlux;

    localparam t_wlux      NO_READING    = -21'sd61;
    localparam logic [1:0] LIMIT_AT_RST  = 2'd2;
    localparam int         THRESHOLD_DIV = 5;

    // Slot of the middle value, indexed by {h0 > h1, h1 > h2, h0 > h2}.
    localparam logic [1:0] MEDIAN_SLOT [8] = '{2'd1, 2'd0, 2'd2, 2'd0,
                                               2'd0, 2'd2, 2'd0, 2'd1};

    t_wlux       shown_lux;
    logic [1:0]  over_run;
    t_wlux       lux_hist [3];
    logic [1:0]  report_limit;
    logic [23:0] pending_reports [$];
    int          err_count = 0;

    assign o_errors = err_count;

    // Applies one accepted request to the filter state and queues any report.
    task automatic apply_request(input t_kind kind, input logic [15:0] raw);
        t_wlux      lux;
        int         gap;
        int         bound;
        logic [2:0] run_next;
        logic [1:0] need;
        logic [2:0] sel;
        if (kind == KIND_CLEAR) begin
            for (int i = 0; i < 3; i++) lux_hist[i] = NO_READING;
        end else begin
            lux   = {2'b00, raw, 3'b000};
            gap   = int'(lux) - int'(shown_lux);
            if (gap < 0) gap = -gap;
            bound = int'(shown_lux) / THRESHOLD_DIV;
            if (gap > bound) begin
                run_next    = {1'b0, over_run} + 3'd1;
                lux_hist[2] = lux_hist[1];
                lux_hist[1] = lux_hist[0];
                lux_hist[0] = lux;
            end else begin
                run_next = 3'd0;
            end
            // A limit of zero behaves like one.
            need = (report_limit == 2'd0) ? 2'd1 : report_limit;
            if (run_next >= {1'b0, need}) begin
                over_run  = 2'd0;
                sel       = {lux_hist[0] > lux_hist[1], lux_hist[1] > lux_hist[2],
                             lux_hist[0] > lux_hist[2]};
                shown_lux = lux_hist[MEDIAN_SLOT[sel]];
                pending_reports.push_back({4'h0, shown_lux[19:0]});
            end else begin
                over_run = run_next[1:0];
            end
        end
    endtask

    // Everything is sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        logic [23:0] want;
        if (!i_rst_n) begin
            shown_lux    = '0;
            over_run     = '0;
            report_limit = LIMIT_AT_RST;
            for (int i = 0; i < 3; i++) lux_hist[i] = NO_READING;
            pending_reports.delete();
        end else begin
            if (i_cfg_we) report_limit = i_cfg_wdata;

            // Compare a delivered report with the oldest prediction.
            if (i_m_tvalid && i_m_tready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected lux report, expected none, got %0d (0x%06h)",
                             $time, $signed(i_m_tdata[19:0]), i_m_tdata);
                    err_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (i_m_tdata !== want) begin
                        $display("%0t: lux report mismatch, expected %0d (0x%06h), got %0d (0x%06h)",
                                 $time, $signed(want[19:0]), want,
                                 $signed(i_m_tdata[19:0]), i_m_tdata);
                        err_count++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) apply_request(t_kind'(i_s_tuser[0]), i_s_tdata);
        end
        o_pending <= pending_reports.size();
    end

endmodule

>>> verif/lux_change_median_filter_core_test.sv
// Top of the lux change median filter regression: clock, reset, stimulus and verdict.
// Depends on lcmf_pkg, the block under test and lcmf_report_checker.
`timescale 1ns / 1ps

module lux_change_median_filter_core_test;
    import lcmf_pkg::*;

    localparam int MAX_CYCLES       = 300000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int RANDOM_PER_PHASE = 310;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [15:0] i_s_tdata   = '0;
    logic [0:0]  i_s_tuser   = '0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_wdata = '0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [23:0] o_m_tdata;

    int send_gap   = 14;
    int recv_stall = 83;
    int cycle_cnt  = 0;
    int fail_count;
    int reports_due;

    always #5 i_clk = ~i_clk;

    lux_change_median_filter_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    lcmf_report_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (fail_count),
        .o_pending   (reports_due)
    );

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == MAX_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one request after an optional random gap and waits until it is taken.
    task automatic push(input t_kind kind, input logic [15:0] raw);
        while ($urandom_range(0, 99) < send_gap) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= raw;
        i_s_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Waits until every predicted report has come out and the pipeline is empty.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (reports_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly runs of similar readings around a level, so the count both builds
    // up and gets cleared; the rest is clears, noise and extreme readings.
    task automatic run_random(input int count);
        int level;
        int run_left;
        int pick;
        int raw;
        level    = 0;
        run_left = 0;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                push(KIND_CLEAR, 16'($urandom));
            end else if (pick < 11) begin
                push(KIND_SAMPLE, 16'($urandom));
            end else if (pick < 15) begin
                push(KIND_SAMPLE, pick[0] ? 16'hFFFF : 16'h0000);
            end else begin
                if (run_left == 0) begin
                    case ($urandom_range(0, 4))
                        0, 1:    level = $urandom_range(0, 65535);
                        2, 3:    level = $urandom_range(0, 255);
                        default: level = $urandom_range(0, 15);
                    endcase
                    run_left = $urandom_range(1, 7);
                end
                raw = level + int'($urandom_range(0, level / 8)) - level / 16;
                if (raw > 65535) raw = 65535;
                run_left--;
                push(KIND_SAMPLE, raw[15:0]);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset limit: steady zero, full-scale pair, clear, then a small pair.
        push(KIND_SAMPLE, 16'h0000);
        push(KIND_SAMPLE, 16'h0000);
        push(KIND_SAMPLE, 16'hFFFF);
        push(KIND_SAMPLE, 16'hFFFF);
        push(KIND_CLEAR,  16'hFFFF);
        push(KIND_SAMPLE, 16'h0001);
        push(KIND_SAMPLE, 16'h0001);

        // Limit of one: a clear followed by one sample reports the sentinel,
        // and the negative reported value lets the next sample through.
        write_limit(2'd1);
        push(KIND_SAMPLE, 16'd0);
        push(KIND_CLEAR,  16'd0);
        push(KIND_SAMPLE, 16'd100);
        push(KIND_SAMPLE, 16'd5);

        // Build a count of two under a limit of three, then lower the limit.
        write_limit(2'd3);
        push(KIND_SAMPLE, 16'd5);
        push(KIND_SAMPLE, 16'd6000);
        push(KIND_SAMPLE, 16'd6000);
        write_limit(2'd1);
        push(KIND_SAMPLE, 16'd6000);

        // A limit of zero acts as one.
        write_limit(2'd0);
        push(KIND_SAMPLE, 16'd30000);
        push(KIND_SAMPLE, 16'd30001);

        // Three distinct samples under the top limit pick a true median.
        write_limit(2'd3);
        push(KIND_SAMPLE, 16'd1000);
        push(KIND_SAMPLE, 16'd3000);
        push(KIND_SAMPLE, 16'd2000);
        push(KIND_SAMPLE, 16'd2000);

        // Random phases: slow receiver, then slow sender, then no idling.
        write_limit(2'd2);
        run_random(RANDOM_PER_PHASE);

        write_limit(2'd3);
        send_gap   <= 83;
        recv_stall <= 14;
        run_random(RANDOM_PER_PHASE);

        write_limit(2'($urandom_range(0, 3)));
        send_gap   <= 0;
        recv_stall <= 0;
        run_random(RANDOM_PER_PHASE);

        settle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/lcmf_pkg.sv
rtl/lcmf_change_det.sv
rtl/lcmf_history.sv
rtl/lux_change_median_filter_core.sv
rtl/lcmf_checker.sv
verif/lcmf_report_checker.sv
verif/lux_change_median_filter_core_test.sv
